// File: design/dpu_pkg.sv
// Shared types and fixed constants for the depth pixel unprojection block.
package dpu_pkg;

    // Field widths of the input and result items.
    localparam int COORD_W   = 24;
    localparam int DEPTH_W   = 16;
    localparam int POINT_Z_W = 23;

    // Output format and unit conversion.
    localparam int OUT_FRAC_BITS = 16;
    localparam int MM_PER_METRE  = 1000;

    // Number of divider lanes: x, y and z.
    localparam int LANES = 3;

    // Input item: one depth pixel.
    typedef struct packed {
        logic signed [COORD_W-1:0] plane_x;
        logic signed [COORD_W-1:0] plane_y;
        logic [DEPTH_W-1:0]        depth_mm;
    } dpu_in_t;

    // Result item: one 3D point.
    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [POINT_Z_W-1:0]      point_z;
    } dpu_out_t;

    // Per-item data carried alongside the square root pipeline.
    typedef struct packed {
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [DEPTH_W-1:0] depth;
        logic               neg_x;
        logic               neg_y;
    } dpu_side_t;

    // Sign flags carried alongside the divider pipeline.
    typedef struct packed {
        logic neg_x;
        logic neg_y;
    } dpu_tag_t;

endpackage

// File: design/dpu_front.sv
// Front end: magnitudes, squares and the sum x*x + y*y + 1 in three register stages.
module dpu_front
    import dpu_pkg::*;
#(
    parameter int F = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  dpu_in_t               pixel,
    output logic                  out_valid,
    output dpu_side_t             side,
    output logic [2*((F > COORD_W-1) ? F : COORD_W-1)+1:0] sum
);

    localparam int M    = (F > COORD_W-1) ? F : COORD_W-1;
    localparam int S_W  = 2 * M + 2;
    localparam int SQ_W = 2 * COORD_W;
    localparam logic [S_W-1:0] ONE_SQ = S_W'(1) << (2 * F);

    logic [COORD_W-1:0] ux;
    logic [COORD_W-1:0] uy;
    dpu_side_t          side1_next;

    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;
    dpu_side_t          side1_reg;
    dpu_side_t          side2_reg;
    dpu_side_t          side3_reg;
    logic [SQ_W-1:0]    sq_x_reg;
    logic [SQ_W-1:0]    sq_y_reg;
    logic [S_W-1:0]     sum_reg;

    // Stage one: split each coordinate into sign and magnitude.
    assign ux = pixel.plane_x;
    assign uy = pixel.plane_y;

    always_comb
    begin
        side1_next.neg_x = pixel.plane_x[COORD_W-1];
        side1_next.neg_y = pixel.plane_y[COORD_W-1];
        side1_next.ax    = pixel.plane_x[COORD_W-1] ? (~ux + 1'b1) : ux;
        side1_next.ay    = pixel.plane_y[COORD_W-1] ? (~uy + 1'b1) : uy;
        side1_next.depth = pixel.depth_mm;
    end

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage two squares the magnitudes; stage three adds them to one squared.
    always_ff @(posedge clk)
    begin
        side1_reg <= side1_next;
        side2_reg <= side1_reg;
        sq_x_reg  <= SQ_W'(side1_reg.ax) * SQ_W'(side1_reg.ax);
        sq_y_reg  <= SQ_W'(side1_reg.ay) * SQ_W'(side1_reg.ay);
        side3_reg <= side2_reg;
        sum_reg   <= S_W'(sq_x_reg) + S_W'(sq_y_reg) + ONE_SQ;
    end

    assign out_valid = v3_reg;
    assign side      = side3_reg;
    assign sum       = sum_reg;

endmodule

// File: design/dpu_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
module dpu_sqrt
    import dpu_pkg::*;
#(
    parameter int F = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  dpu_side_t             side_in,
    input  logic [2*((F > COORD_W-1) ? F : COORD_W-1)+1:0] sum,
    output logic                  out_valid,
    output dpu_side_t             side_out,
    output logic [((F > COORD_W-1) ? F : COORD_W-1):0] root
);

    localparam int M    = (F > COORD_W-1) ? F : COORD_W-1;
    localparam int R_W  = M + 1;
    localparam int S_W  = 2 * M + 2;
    localparam int RM_W = R_W + 2;
    localparam int A_W  = RM_W + 2;

    // Values entering each stage.
    logic            v_cur    [0:R_W-1];
    logic [S_W-1:0]  s_cur    [0:R_W-1];
    logic [RM_W-1:0] rem_cur  [0:R_W-1];
    logic [R_W-1:0]  root_cur [0:R_W-1];
    dpu_side_t       side_cur [0:R_W-1];

    // Stage registers and their next values.
    logic            valid_next [1:R_W];
    logic [R_W-1:0]  root_next  [1:R_W];
    dpu_side_t       side_next  [1:R_W];
    logic [S_W-1:0]  s_next     [1:R_W-1];
    logic [RM_W-1:0] rem_next   [1:R_W-1];

    logic            valid_reg [1:R_W];
    logic [R_W-1:0]  root_reg  [1:R_W];
    dpu_side_t       side_reg  [1:R_W];
    logic [S_W-1:0]  s_reg     [1:R_W-1];
    logic [RM_W-1:0] rem_reg   [1:R_W-1];

    genvar k;
    generate
        for (k = 0; k < R_W; k++)
        begin : g_stage
            logic [A_W-1:0] acc;
            logic [A_W-1:0] trial;
            logic           take;

            // The first stage starts from the sum with an empty remainder.
            if (k == 0)
            begin : g_first
                assign v_cur[k]    = in_valid;
                assign s_cur[k]    = sum;
                assign rem_cur[k]  = '0;
                assign root_cur[k] = '0;
                assign side_cur[k] = side_in;
            end
            else
            begin : g_later
                assign v_cur[k]    = valid_reg[k];
                assign s_cur[k]    = s_reg[k];
                assign rem_cur[k]  = rem_reg[k];
                assign root_cur[k] = root_reg[k];
                assign side_cur[k] = side_reg[k];
            end

            // Bring down the next two bits and try the root bit as one.
            assign acc   = {rem_cur[k], s_cur[k][S_W-1 -: 2]};
            assign trial = A_W'({root_cur[k], 2'b01});
            assign take  = (acc >= trial);

            assign valid_next[k+1] = v_cur[k];
            assign root_next[k+1]  = {root_cur[k][R_W-2:0], take};
            assign side_next[k+1]  = side_cur[k];

            // The last stage drops the sum and remainder and keeps the root.
            if (k < R_W - 1)
            begin : g_keep
                logic [A_W-1:0] diff;

                assign diff          = acc - trial;
                assign s_next[k+1]   = s_cur[k] << 2;
                assign rem_next[k+1] = take ? diff[RM_W-1:0] : acc[RM_W-1:0];
            end
        end
    endgenerate

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= R_W; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            for (int i = 1; i <= R_W; i++)
            begin
                valid_reg[i] <= valid_next[i];
            end
        end
    end

    // Payload registers of every stage.
    always_ff @(posedge clk)
    begin
        for (int i = 1; i <= R_W; i++)
        begin
            root_reg[i] <= root_next[i];
            side_reg[i] <= side_next[i];
        end
        for (int i = 1; i < R_W; i++)
        begin
            s_reg[i]   <= s_next[i];
            rem_reg[i] <= rem_next[i];
        end
    end

    assign out_valid = valid_reg[R_W];
    assign side_out  = side_reg[R_W];
    assign root      = root_reg[R_W];

endmodule

// File: design/dpu_scale.sv
// Forms the rounded division operands: numerators and twice the scaled ray length.
module dpu_scale
    import dpu_pkg::*;
#(
    parameter int F = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  dpu_side_t             side,
    input  logic [((F > COORD_W-1) ? F : COORD_W-1):0] root,
    output logic                  out_valid,
    output dpu_tag_t              tag,
    output logic [LANES-1:0][((F > COORD_W-1) ? F : COORD_W-1)+33:0] num,
    output logic [((F > COORD_W-1) ? F : COORD_W-1)+11:0] d2
);

    localparam int M      = (F > COORD_W-1) ? F : COORD_W-1;
    localparam int R_W    = M + 1;
    localparam int D_W    = R_W + 11;
    localparam int N_W    = M + 34;
    localparam int PROD_W = COORD_W + DEPTH_W;

    logic                          vp_reg;
    logic                          vq_reg;
    dpu_tag_t                      tag_p_reg;
    dpu_tag_t                      tag_q_reg;
    logic [D_W-1:0]                den2_reg;
    logic [D_W-1:0]                d2_reg;
    logic [PROD_W-1:0]             prod_x_reg;
    logic [PROD_W-1:0]             prod_y_reg;
    logic [DEPTH_W-1:0]            depth_reg;
    logic [N_W-1:0]                den_ext;
    logic [LANES-1:0][N_W-1:0]     num_next;
    logic [LANES-1:0][N_W-1:0]     num_reg;

    // Valid bits of the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
            vq_reg <= 1'b0;
        end
        else
        begin
            vp_reg <= in_valid;
            vq_reg <= vp_reg;
        end
    end

    // Numerator of each rounded quotient is twice the product plus the denominator.
    assign den_ext = N_W'(den2_reg >> 1);

    always_comb
    begin
        num_next[0] = (N_W'(prod_x_reg) << (OUT_FRAC_BITS + 1)) + den_ext;
        num_next[1] = (N_W'(prod_y_reg) << (OUT_FRAC_BITS + 1)) + den_ext;
        num_next[2] = (N_W'(depth_reg) << (F + OUT_FRAC_BITS + 1)) + den_ext;
    end

    // First stage multiplies, second stage adds.
    always_ff @(posedge clk)
    begin
        tag_p_reg.neg_x <= side.neg_x;
        tag_p_reg.neg_y <= side.neg_y;
        den2_reg        <= D_W'(root) * D_W'(2 * MM_PER_METRE);
        prod_x_reg      <= PROD_W'(side.ax) * PROD_W'(side.depth);
        prod_y_reg      <= PROD_W'(side.ay) * PROD_W'(side.depth);
        depth_reg       <= side.depth;
        tag_q_reg       <= tag_p_reg;
        d2_reg          <= den2_reg;
        num_reg         <= num_next;
    end

    assign out_valid = vq_reg;
    assign tag       = tag_q_reg;
    assign num       = num_reg;
    assign d2        = d2_reg;

endmodule

// File: design/dpu_div.sv
// Three-lane pipelined restoring divider, one quotient bit per register stage.
module dpu_div
    import dpu_pkg::*;
#(
    parameter int F = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  dpu_tag_t              tag_in,
    input  logic [LANES-1:0][((F > COORD_W-1) ? F : COORD_W-1)+33:0] num,
    input  logic [((F > COORD_W-1) ? F : COORD_W-1)+11:0] d2,
    output logic                  out_valid,
    output dpu_tag_t              tag_out,
    output logic [LANES-1:0][POINT_Z_W-1:0] quo
);

    localparam int M   = (F > COORD_W-1) ? F : COORD_W-1;
    localparam int D_W = M + 12;
    localparam int N_W = M + 34;
    localparam int Q_W = POINT_Z_W;

    // Values entering each stage.
    logic            v_cur   [0:Q_W-1];
    dpu_tag_t        tag_cur [0:Q_W-1];
    logic [D_W-1:0]  d2_cur  [0:Q_W-1];
    logic [D_W-1:0]  rem_cur [0:LANES-1][0:Q_W-1];
    logic [Q_W-1:0]  nlo_cur [0:LANES-1][0:Q_W-1];
    logic [Q_W-1:0]  q_cur   [0:LANES-1][0:Q_W-1];

    // Stage registers and their next values.
    logic            valid_next [1:Q_W];
    dpu_tag_t        tag_next   [1:Q_W];
    logic [D_W-1:0]  d2_next    [1:Q_W-1];
    logic [D_W-1:0]  rem_next   [0:LANES-1][1:Q_W-1];
    logic [Q_W-1:0]  nlo_next   [0:LANES-1][1:Q_W-1];
    logic [Q_W-1:0]  q_next     [0:LANES-1][1:Q_W];

    logic            valid_reg [1:Q_W];
    dpu_tag_t        tag_reg   [1:Q_W];
    logic [D_W-1:0]  d2_reg    [1:Q_W-1];
    logic [D_W-1:0]  rem_reg   [0:LANES-1][1:Q_W-1];
    logic [Q_W-1:0]  nlo_reg   [0:LANES-1][1:Q_W-1];
    logic [Q_W-1:0]  q_reg     [0:LANES-1][1:Q_W];

    genvar k;
    genvar l;
    generate
        for (k = 0; k < Q_W; k++)
        begin : g_stage
            // Control and divisor shared by the three lanes.
            if (k == 0)
            begin : g_first
                assign v_cur[k]   = in_valid;
                assign tag_cur[k] = tag_in;
                assign d2_cur[k]  = d2;
            end
            else
            begin : g_later
                assign v_cur[k]   = valid_reg[k];
                assign tag_cur[k] = tag_reg[k];
                assign d2_cur[k]  = d2_reg[k];
            end

            assign valid_next[k+1] = v_cur[k];
            assign tag_next[k+1]   = tag_cur[k];

            if (k < Q_W - 1)
            begin : g_keep_d2
                assign d2_next[k+1] = d2_cur[k];
            end

            for (l = 0; l < LANES; l++)
            begin : g_lane
                logic [D_W:0] acc;
                logic         take;

                // The upper numerator bits seed the remainder; the quotient fits Q_W bits.
                if (k == 0)
                begin : g_first
                    assign rem_cur[l][k] = D_W'(num[l][N_W-1:Q_W]);
                    assign nlo_cur[l][k] = num[l][Q_W-1:0];
                    assign q_cur[l][k]   = '0;
                end
                else
                begin : g_later
                    assign rem_cur[l][k] = rem_reg[l][k];
                    assign nlo_cur[l][k] = nlo_reg[l][k];
                    assign q_cur[l][k]   = q_reg[l][k];
                end

                // Shift in one numerator bit and subtract the divisor where it fits.
                assign acc  = {rem_cur[l][k], nlo_cur[l][k][Q_W-1]};
                assign take = (acc >= {1'b0, d2_cur[k]});
                assign q_next[l][k+1] = {q_cur[l][k][Q_W-2:0], take};

                if (k < Q_W - 1)
                begin : g_keep
                    logic [D_W:0] diff;

                    assign diff             = acc - {1'b0, d2_cur[k]};
                    assign rem_next[l][k+1] = take ? diff[D_W-1:0] : acc[D_W-1:0];
                    assign nlo_next[l][k+1] = nlo_cur[l][k] << 1;
                end
            end
        end

        // Each lane's quotient leaves from its last stage.
        for (l = 0; l < LANES; l++)
        begin : g_quo
            assign quo[l] = q_reg[l][Q_W];
        end
    endgenerate

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= Q_W; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            for (int i = 1; i <= Q_W; i++)
            begin
                valid_reg[i] <= valid_next[i];
            end
        end
    end

    // Payload registers of every stage and lane.
    always_ff @(posedge clk)
    begin
        for (int i = 1; i <= Q_W; i++)
        begin
            tag_reg[i] <= tag_next[i];
        end
        for (int i = 1; i < Q_W; i++)
        begin
            d2_reg[i] <= d2_next[i];
        end
        for (int j = 0; j < LANES; j++)
        begin
            for (int i = 1; i <= Q_W; i++)
            begin
                q_reg[j][i] <= q_next[j][i];
            end
            for (int i = 1; i < Q_W; i++)
            begin
                rem_reg[j][i] <= rem_next[j][i];
                nlo_reg[j][i] <= nlo_next[j][i];
            end
        end
    end

    assign out_valid = valid_reg[Q_W];
    assign tag_out   = tag_reg[Q_W];

endmodule

// File: design/depth_pixel_unprojection.sv
// Top level of the depth pixel unprojection block: pipeline assembly and result register.
//
// Usage:
//   Input channel: drive pixel and raise start for one cycle per item. busy is held
//   low, so an item is accepted at every rising edge at which start is high; items
//   may follow one another in consecutive cycles.
//   Result channel: each point appears on point for exactly one cycle, marked by done.
//   The receiver cannot stall the block and must take every result as it comes.
//   Throughput: one item per cycle, sustained. Most of the pipeline depth lies in the
//   square root pipeline, one root bit per stage, and the divider, one quotient bit
//   per stage over 23 stages for the three axes in parallel.
//   Reset clears every valid bit at once, so items in flight are dropped and no done
//   pulse follows; there is no state to restore and no clearing pass.
//   Results come out in the order in which the items went in.
//
module depth_pixel_unprojection
    import dpu_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 20
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  dpu_in_t  pixel,
    output logic     done,
    output dpu_out_t point
);

    localparam int M       = (COORD_FRAC_BITS > COORD_W-1) ? COORD_FRAC_BITS : COORD_W-1;
    localparam int R_W     = M + 1;
    localparam int S_W     = 2 * M + 2;
    localparam int D_W     = M + 12;
    localparam int N_W     = M + 34;
    localparam int LATENCY = M + 30;

    logic                           accept;
    logic                           front_valid;
    dpu_side_t                      front_side;
    logic [S_W-1:0]                 front_sum;
    logic                           sqrt_valid;
    dpu_side_t                      sqrt_side;
    logic [R_W-1:0]                 sqrt_root;
    logic                           scale_valid;
    dpu_tag_t                       scale_tag;
    logic [LANES-1:0][N_W-1:0]      scale_num;
    logic [D_W-1:0]                 scale_d2;
    logic                           div_valid;
    dpu_tag_t                       div_tag;
    logic [LANES-1:0][POINT_Z_W-1:0] div_quo;
    logic [COORD_W-1:0]             mag_x;
    logic [COORD_W-1:0]             mag_y;
    dpu_out_t                       point_next;
    dpu_out_t                       point_reg;
    logic                           done_reg;

    // The pipeline never stalls, so every start is taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    dpu_front #(
        .F (COORD_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .pixel     (pixel),
        .out_valid (front_valid),
        .side      (front_side),
        .sum       (front_sum)
    );

    dpu_sqrt #(
        .F (COORD_FRAC_BITS)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .side_in   (front_side),
        .sum       (front_sum),
        .out_valid (sqrt_valid),
        .side_out  (sqrt_side),
        .root      (sqrt_root)
    );

    dpu_scale #(
        .F (COORD_FRAC_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sqrt_valid),
        .side      (sqrt_side),
        .root      (sqrt_root),
        .out_valid (scale_valid),
        .tag       (scale_tag),
        .num       (scale_num),
        .d2        (scale_d2)
    );

    dpu_div #(
        .F (COORD_FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scale_valid),
        .tag_in    (scale_tag),
        .num       (scale_num),
        .d2        (scale_d2),
        .out_valid (div_valid),
        .tag_out   (div_tag),
        .quo       (div_quo)
    );

    // Restore the signs of the lateral components.
    assign mag_x = COORD_W'(div_quo[0]);
    assign mag_y = COORD_W'(div_quo[1]);

    always_comb
    begin
        point_next.point_x = div_tag.neg_x ? (~mag_x + 1'b1) : mag_x;
        point_next.point_y = div_tag.neg_y ? (~mag_y + 1'b1) : mag_y;
        point_next.point_z = div_quo[2];
    end

    // Result register and its strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        point_reg <= point_next;
    end

    assign done  = done_reg;
    assign point = point_reg;

    // A result is only ever produced for an accepted item.
    a_done_has_item : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result strobe without a matching item");

    // Every accepted item yields its result.
    a_item_has_done : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted item produced no result");

    // A pixel with no depth reading maps to the origin.
    a_zero_depth : assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(pixel.depth_mm, LATENCY) == '0)) |->
        ((point.point_x == '0) && (point.point_y == '0) && (point.point_z == '0)))
        else $error("zero depth gave a non-zero point");

endmodule
